// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files of the sorted priority queue
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
// shared types, constants and opcodes of the sorted priority queue
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   // number of cells in the row
   localparam int CAPACITY = 64;
   // width of the internal entry count, able to hold CAPACITY itself
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   // fixed widths of the channel fields
   localparam int ENTRY_W  = 7;
   localparam int KEY_W    = 32;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef struct packed {
      logic [1:0] opcode;
      key_type    key;
   } req_payload_type;

   typedef struct packed {
      key_type            popped_key;
      logic               found;
      logic               was_empty;
      logic               overflow;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_payload_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic    load;     // an item transfers this cycle
      logic    insert;   // insert that fits into the store
      logic    pop;      // pop of a non-empty store
      key_type key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_ifs.sv -----
// valid/ready channel interfaces for the request and response sides
// depends on spq_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if import spq_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue of signed 32-bit keys held in a row of compare/shift cells.
// Channels: req_chan carries opcode and key (insert, pop smallest, query);
// rsp_chan returns popped_key, found, was_empty, overflow and entry_count,
// one response for every request, in request order.
// Each request updates the cell row in the cycle it transfers: every cell
// compares its key with the request key and its neighbors, so an insert,
// pop or query is a single update of the row.
// Response path: the capture stage loads at the request transfer, then the
// output register loads from it once that register is free, and rsp_chan.valid
// rises when the response sits in the output register.
// Throughput: one request per cycle while rsp_chan.ready stays high.
// A stalled receiver holds the output register; one more request is taken
// into the capture stage, then req_chan.ready drops until the output drains.
// Reset (synchronous, active high) empties the store and drops pending
// responses; keys in the cells are not cleared and stay unread until written.
// An insert into a full store and a pop of an empty store leave it unchanged
// and are flagged in the response.
// depends on spq_pkg, spq_ifs, spq_chain, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   spq_req_if.sink          req_chan,
   spq_rsp_if.source        rsp_chan
);

   count_type           count_ff, count_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_query_ff, s1_query_in;
   key_type             s1_popped_ff, s1_popped_in;
   logic                s1_empty_ff, s1_empty_in;
   logic                s1_ovf_ff, s1_ovf_in;
   count_type           s1_count_ff, s1_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                req_xfer;
   logic                s1_advance;
   logic                is_insert, is_pop, is_query;
   logic                full, empty;
   cell_ctl_type        ctl;
   key_type             head_key;
   logic [CAPACITY-1:0] match_vec;

   // handshake: capture stage moves on when the output register frees up
   assign s1_advance      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready  = !s1_valid_ff || s1_advance;
   assign req_xfer        = req_chan.valid && req_chan.ready;

   // decode
   assign is_insert = req_chan.payload.opcode == OP_INSERT;
   assign is_pop    = req_chan.payload.opcode == OP_POP;
   assign is_query  = req_chan.payload.opcode == OP_QUERY;
   assign full      = count_ff == COUNT_W'(CAPACITY);
   assign empty     = count_ff == '0;

   // command to the cell row
   always_comb begin
      ctl.load   = req_xfer;
      ctl.insert = req_xfer && is_insert && !full;
      ctl.pop    = req_xfer && is_pop && !empty;
      ctl.key    = req_chan.payload.key;
   end

   spq_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .count     (count_ff),
      .head_key  (head_key),
      .match_vec (match_vec)
   );

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // capture stage
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_query_in  = s1_query_ff;
      s1_popped_in = s1_popped_ff;
      s1_empty_in  = s1_empty_ff;
      s1_ovf_in    = s1_ovf_ff;
      s1_count_in  = s1_count_ff;
      if (req_xfer) begin
         s1_valid_in  = 1'b1;
         s1_query_in  = is_query;
         s1_popped_in = ctl.pop ? head_key : '0;
         s1_empty_in  = is_pop && empty;
         s1_ovf_in    = is_insert && full;
         s1_count_in  = count_in;
      end else if (s1_advance) begin
         s1_valid_in  = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (s1_advance) begin
         rsp_valid_in               = s1_valid_ff;
         rsp_payload_in.popped_key  = s1_popped_ff;
         rsp_payload_in.found       = s1_query_ff && (|match_vec);
         rsp_payload_in.was_empty   = s1_empty_ff;
         rsp_payload_in.overflow    = s1_ovf_ff;
         rsp_payload_in.entry_count = ENTRY_W'(s1_count_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_query_ff    <= s1_query_in;
      s1_popped_ff   <= s1_popped_in;
      s1_empty_ff    <= s1_empty_in;
      s1_ovf_ff      <= s1_ovf_in;
      s1_count_ff    <= s1_count_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(CAPACITY))
   `ASSERT_ALWAYS(a_ovf_full, clock, reset,
      !(rsp_valid_ff && rsp_payload_ff.overflow) ||
      rsp_payload_ff.entry_count == ENTRY_W'(CAPACITY))
   `ASSERT_ALWAYS(a_empty_zero, clock, reset,
      !(rsp_valid_ff && rsp_payload_ff.was_empty) ||
      (rsp_payload_ff.entry_count == '0 && rsp_payload_ff.popped_key == '0))
   `ASSERT_NEXT(a_pop_count, clock, reset, ctl.pop,
      count_ff == $past(count_ff) - COUNT_W'(1))

endmodule

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// one cell of the sorted row: holds a key, shifts right on insert, left on pop
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         valid,      // cell holds a stored key
   input  logic         left_less,  // left neighbor key is below the new key
   input  key_type      left_key,
   input  key_type      right_key,
   output key_type      key_out,
   output logic         less_out,
   output logic         match_out
);

   key_type key_ff, key_in;
   logic    match_ff, match_in;

   // own key sorts strictly below the incoming key
   assign less_out = valid && (key_ff < ctl.key);

   // insert keeps, takes the new key, or takes the left key; pop takes the right key
   always_comb begin
      key_in = key_ff;
      if (ctl.insert) begin
         if (less_out) begin
            key_in = key_ff;
         end else if (left_less) begin
            key_in = ctl.key;
         end else begin
            key_in = left_key;
         end
      end else if (ctl.pop) begin
         key_in = right_key;
      end
   end

   // equality flag captured at each transfer for the query result
   assign match_in = ctl.load ? (valid && (key_ff == ctl.key)) : match_ff;

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/spq_chain.sv -----
// row of CAPACITY cells, each wired to its left and right neighbor where it has one
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none

module spq_chain import spq_pkg::*; (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  count_type           count,
   output key_type             head_key,
   output logic [CAPACITY-1:0] match_vec
);

   key_type             key_vec  [CAPACITY];
   logic [CAPACITY-1:0] less_vec;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    valid;
      logic    left_less;
      key_type left_key;
      key_type right_key;

      // cells below the count hold stored keys
      assign valid = COUNT_W'(i) < count;

      // head cell sees an always-smaller left neighbor
      if (i == 0) begin : g_head
         assign left_less = 1'b1;
         assign left_key  = key_vec[0];
      end else begin : g_body
         assign left_less = less_vec[i-1];
         assign left_key  = key_vec[i-1];
      end

      // tail cell keeps its own key on pop
      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = key_vec[i];
      end else begin : g_inner
         assign right_key = key_vec[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .valid     (valid),
         .left_less (left_less),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (key_vec[i]),
         .less_out  (less_vec[i]),
         .match_out (match_vec[i])
      );
   end

   assign head_key = key_vec[0];

endmodule

`default_nettype wire
